@@ design/osml_pkg.sv @@
// ----------------------------------------------------------------------------
// osml_pkg
// Shared types and constants of the one-shot modifier and layer block.
// ----------------------------------------------------------------------------
package osml_pkg;

   localparam int ByteW      = 8;
   localparam int KeyW       = 16;
   localparam int TimeW      = 32;
   localparam int ReqDataW   = 56;
   localparam int RspDataW   = 40;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 32;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [ByteW-1:0] StreakMax = 8'hFF;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_MOD_PREFIX   = 2'd0,
      CSR_LAYER_PREFIX = 2'd1,
      CSR_TAP_TOGGLE   = 2'd2,
      CSR_TIMEOUT      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ByteW-1:0] mod_prefix;
      logic [ByteW-1:0] layer_prefix;
      logic [ByteW-1:0] tap_toggle;
      logic [TimeW-1:0] timeout_ms;
   } cfg_type;

   // classified event as it sits in the queue
   typedef struct packed {
      logic             tick;
      logic             is_mod;
      logic             is_layer;
      logic             pressed;
      logic             key_nonzero;
      logic [KeyW-1:0]  keycode;
      logic [TimeW-1:0] time_ms;
   } item_type;

   typedef struct packed {
      logic             pass_through;
      logic [ByteW-1:0] mod_press_mask;
      logic [ByteW-1:0] mod_release_mask;
      logic             layer_on;
      logic             layer_off;
      logic [ByteW-1:0] layer_index;
      logic [ByteW-1:0] mods_pending;
   } result_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

@@ design/osml_front.sv @@
// ----------------------------------------------------------------------------
// osml_front
// Unpacks request transfers and classifies each key event by its prefix.
// ----------------------------------------------------------------------------
module osml_front
   import osml_pkg::*;
(
   input  osml_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   input  logic [osml_pkg::ReqDataW-1:0]       req_tdata,
   output logic                                push_valid,
   input  logic                                push_ready,
   output osml_pkg::item_type                  push_item
);
   import osml_pkg::*;

   logic [ByteW-1:0] key_hi;
   logic             hit_mod;

   always_comb begin
      push_item.keycode     = req_tdata[KeyW-1:0];
      push_item.pressed     = req_tdata[KeyW];
      push_item.time_ms     = req_tdata[KeyW+TimeW:KeyW+1];
      push_item.tick        = req_tuser;
      key_hi                = push_item.keycode[KeyW-1:ByteW];
      hit_mod               = (key_hi == cfg.mod_prefix);
      push_item.is_mod      = hit_mod;
      push_item.is_layer    = !hit_mod && (key_hi == cfg.layer_prefix);
      push_item.key_nonzero = (push_item.keycode != '0);
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

@@ design/osml_queue.sv @@
// ----------------------------------------------------------------------------
// osml_queue
// Short queue that decouples event classification from state update.
// ----------------------------------------------------------------------------
module osml_queue
   import osml_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push_valid,
   output logic                             push_ready,
   input  osml_pkg::item_type               push_item,
   output osml_pkg::queue_out_type          pop_out,
   input  logic                             pop_ready,
   output logic [osml_pkg::QueueCntW-1:0]   level
);
   import osml_pkg::*;

   item_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      push_ready    = (count_ff != QueueCntW'(QueueDepth));
      pop_out.valid = (count_ff != '0);
      pop_out.item  = entry_ff[rd_ptr_ff];
      do_push       = push_valid && push_ready;
      do_pop        = pop_out.valid && pop_ready;
      wr_ptr_in     = do_push ? QueuePtrW'((32'(wr_ptr_ff) + 1) % QueueDepth) : wr_ptr_ff;
      rd_ptr_in     = do_pop  ? QueuePtrW'((32'(rd_ptr_ff) + 1) % QueueDepth) : rd_ptr_ff;
      count_in      = count_ff + QueueCntW'(do_push) - QueueCntW'(do_pop);
      level         = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/osml_back.sv @@
// ----------------------------------------------------------------------------
// osml_back
// One-shot state update and registered result output.
// ----------------------------------------------------------------------------
module osml_back
   import osml_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  osml_pkg::cfg_type                cfg,
   input  osml_pkg::queue_out_type          pop_in,
   output logic                             pop_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [osml_pkg::RspDataW-1:0]    rsp_tdata
);
   import osml_pkg::*;

   logic [ByteW-1:0] pending_mods_ff,  pending_mods_in;
   logic             layer_pending_ff, layer_pending_in;
   logic [ByteW-1:0] pending_layer_ff, pending_layer_in;
   logic             lock_ff,          lock_in;
   logic [TimeW-1:0] armed_time_ff,    armed_time_in;
   logic [ByteW-1:0] streak_ff,        streak_in;
   logic [KeyW-1:0]  last_key_ff,      last_key_in;
   logic             rsp_valid_ff,     rsp_valid_in;
   result_type       result_ff,        result_in;

   item_type         it;
   logic             do_step;
   logic             drop;
   logic             done;
   logic             anything_pending;
   logic [TimeW-1:0] elapsed;

   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign do_step   = pop_in.valid && pop_ready;
   assign it        = pop_in.item;

   always_comb begin
      pending_mods_in  = pending_mods_ff;
      layer_pending_in = layer_pending_ff;
      pending_layer_in = pending_layer_ff;
      lock_in          = lock_ff;
      armed_time_in    = armed_time_ff;
      streak_in        = streak_ff;
      last_key_in      = last_key_ff;
      result_in        = '0;
      drop             = 1'b0;
      done             = 1'b0;
      anything_pending = (pending_mods_ff != '0) || layer_pending_ff;
      elapsed          = it.time_ms - armed_time_ff;

      if (it.tick) begin
         drop = !lock_ff && anything_pending && (cfg.timeout_ms != '0)
                && (elapsed > cfg.timeout_ms);
      end else if (it.is_mod || it.is_layer) begin
         if (it.pressed) begin
            if (it.keycode == last_key_ff) begin
               streak_in = (streak_ff == StreakMax) ? streak_ff : streak_ff + 8'd1;
            end else begin
               streak_in   = 8'd1;
               last_key_in = it.keycode;
            end
            if ((cfg.tap_toggle != '0) && (streak_in >= cfg.tap_toggle)) begin
               if (lock_ff) begin
                  drop = 1'b1;
                  done = 1'b1;
               end else begin
                  lock_in = 1'b1;
               end
            end
            if (!done) begin
               armed_time_in = it.time_ms;
               if (it.is_mod) begin
                  pending_mods_in          = it.keycode[ByteW-1:0];
                  result_in.mod_press_mask = it.keycode[ByteW-1:0];
               end else begin
                  pending_layer_in      = it.keycode[ByteW-1:0];
                  layer_pending_in      = 1'b1;
                  result_in.layer_on    = 1'b1;
                  result_in.layer_index = it.keycode[ByteW-1:0];
               end
            end
         end
      end else begin
         drop = anything_pending && !lock_ff && !it.pressed && it.key_nonzero;
         if (it.pressed) begin
            last_key_in = '0;
            streak_in   = '0;
         end
         result_in.pass_through = 1'b1;
      end

      // cancel of the pending one-shot
      if (drop) begin
         result_in.mod_release_mask = pending_mods_ff;
         pending_mods_in            = '0;
         if (layer_pending_ff) begin
            result_in.layer_off   = 1'b1;
            result_in.layer_index = pending_layer_ff;
         end
         layer_pending_in = 1'b0;
         lock_in          = 1'b0;
         streak_in        = '0;
      end

      result_in.mods_pending = pending_mods_in;
      rsp_valid_in           = do_step || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_mods_ff  <= '0;
         layer_pending_ff <= 1'b0;
         lock_ff          <= 1'b0;
         streak_ff        <= '0;
         last_key_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_step) begin
            pending_mods_ff  <= pending_mods_in;
            layer_pending_ff <= layer_pending_in;
            lock_ff          <= lock_in;
            streak_ff        <= streak_in;
            last_key_ff      <= last_key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_step) begin
         pending_layer_ff <= pending_layer_in;
         armed_time_ff    <= armed_time_in;
         result_ff        <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0,
                        result_ff.mods_pending,
                        result_ff.layer_index,
                        result_ff.layer_off,
                        result_ff.layer_on,
                        result_ff.mod_release_mask,
                        result_ff.mod_press_mask,
                        result_ff.pass_through};

endmodule

@@ design/one_shot_modifier_layer.sv @@
// ----------------------------------------------------------------------------
// one_shot_modifier_layer
// One-shot modifier and layer keys with tap-to-lock and timeout expiry.
//
//  channel  direction  signals                    contents
//  req      in         req_tvalid/tready/tuser/   tuser command, tdata key event
//                      tdata
//  rsp      out        rsp_tvalid/tready/tdata    key actions and pending mask
//  csr      in         csr_we/index/wdata         prefixes, tap count, timeout
//
// one transfer per cycle sustained while rsp_tready stays high; a request
// passes through front classification into a two-entry queue, then the state
// update into the output register. reset clears the one-shot state and loads
// the register defaults. a stalled rsp side fills the queue, then drops
// req_tready.
// ----------------------------------------------------------------------------
module one_shot_modifier_layer
   import osml_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // command
   // keycode, pressed, time_ms, zero fill
   input  logic [osml_pkg::ReqDataW-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pass_through, mod_press_mask, mod_release_mask, layer_on, layer_off,
   // layer_index, mods_pending, zero fill
   output logic [osml_pkg::RspDataW-1:0]       rsp_tdata,
   input  logic                                csr_we,
   input  logic [osml_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [osml_pkg::CsrDataW-1:0]       csr_wdata
);
   import osml_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   push_valid, push_ready;
   item_type               push_item;
   queue_out_type          pop_bus;
   logic                   pop_ready;
   logic [QueueCntW-1:0]   queue_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MOD_PREFIX:   cfg_in.mod_prefix   = csr_wdata[ByteW-1:0];
            CSR_LAYER_PREFIX: cfg_in.layer_prefix = csr_wdata[ByteW-1:0];
            CSR_TAP_TOGGLE:   cfg_in.tap_toggle   = csr_wdata[ByteW-1:0];
            CSR_TIMEOUT:      cfg_in.timeout_ms   = csr_wdata[TimeW-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mod_prefix   <= 8'd85;
         cfg_ff.layer_prefix <= 8'd84;
         cfg_ff.tap_toggle   <= 8'd5;
         cfg_ff.timeout_ms   <= 32'd3000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   osml_front u_front (
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   osml_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_out    (pop_bus),
      .pop_ready  (pop_ready),
      .level      (queue_level)
   );

   osml_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_in     (pop_bus),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_level <= QueueCntW'(QueueDepth))
      else $error("queue level beyond depth");

   a_layer_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[17] && rsp_tdata[18]))
      else $error("layer on and off in one result");

   a_pass_no_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[8:1] == '0 && !rsp_tdata[17]))
      else $error("pass-through event also arms a one-shot");

   a_layer_on_no_mods: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17]) |-> (rsp_tdata[16:1] == '0))
      else $error("layer arm also changes modifiers");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(queue_level != '0))
      else $error("result without a queued transfer");

endmodule

@@ tb/tb_one_shot_modifier_layer.sv @@
// ----------------------------------------------------------------------------
// tb_one_shot_modifier_layer
// Self-checking testbench for the one-shot modifier and layer block. Key
// events and time ticks are streamed in with random bursts and gaps while the
// response side stalls on its own pattern. A behavioral predictor tracks the
// pending mask, the pending layer, the lock and the tap streak and queues the
// expected key actions, which are compared field by field with each response
// transfer. Directed cases cover arming, cancel, rearming, tap lock, timeout
// with wrapping time, zero prefixes and keycodes, and streak saturation,
// followed by random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_one_shot_modifier_layer;
   import osml_pkg::*;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam int   STALL_LIMIT    = 2000;
   localparam int   HOLD_CYCLES    = 150;
   localparam int   ITEMS_PER_PASS = 180;
   localparam int   MAX_REPORTS    = 10;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic                 req_tuser;   // command
   // keycode, pressed, time_ms, zero fill
   logic [ReqDataW-1:0]  req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // pass_through, mod_press_mask, mod_release_mask, layer_on, layer_off,
   // layer_index, mods_pending, zero fill
   logic [RspDataW-1:0]  rsp_tdata;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   one_shot_modifier_layer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow registers and one-shot state
   cfg_type          cfg;
   logic [7:0]       os_mods;
   logic             os_layer_armed;
   logic [7:0]       os_layer;
   logic             os_locked;
   logic [31:0]      os_armed_at;
   logic [7:0]       os_streak;
   logic [15:0]      last_os_key;

   result_type       key_actions_q[$];
   int               error_count;
   int               sent_count;
   int               burst_left;
   int               hold_requests;
   int               hold_served;
   int               rsp_hold_left;
   int               rsp_mode;
   int               rsp_mode_left;
   int               stall_cycles;
   logic [31:0]      cur_time;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void cancel_one_shot(inout result_type r);
      r.mod_release_mask = r.mod_release_mask | os_mods;
      os_mods = '0;
      if (os_layer_armed) begin
         r.layer_off   = 1'b1;
         r.layer_index = os_layer;
      end
      os_layer_armed = 1'b0;
      os_locked      = 1'b0;
      os_streak      = '0;
   endfunction

   function automatic result_type predict_key_actions(input logic cmd, input logic [15:0] kc,
                                                      input logic pressed,
                                                      input logic [31:0] stamp);
      result_type  r;
      logic        hit_mod;
      logic        hit_layer;
      logic        dropped;
      logic [31:0] elapsed;
      r       = '0;
      dropped = 1'b0;
      if (cmd == CMD_TICK) begin
         elapsed = stamp - os_armed_at;
         if (!os_locked && (os_mods != 0 || os_layer_armed) && cfg.timeout_ms != 0
             && elapsed > cfg.timeout_ms) begin
            cancel_one_shot(r);
         end
      end else begin
         hit_mod   = (kc[15:8] == cfg.mod_prefix);
         hit_layer = !hit_mod && (kc[15:8] == cfg.layer_prefix);
         if (hit_mod || hit_layer) begin
            if (pressed) begin
               if (kc == last_os_key) begin
                  if (os_streak != StreakMax) os_streak = os_streak + 8'd1;
               end else begin
                  os_streak   = 8'd1;
                  last_os_key = kc;
               end
               if (cfg.tap_toggle != 0 && os_streak >= cfg.tap_toggle) begin
                  if (os_locked) begin
                     cancel_one_shot(r);
                     dropped = 1'b1;
                  end else begin
                     os_locked = 1'b1;
                  end
               end
               if (!dropped) begin
                  os_armed_at = stamp;
                  if (hit_mod) begin
                     os_mods          = kc[7:0];
                     r.mod_press_mask = os_mods;
                  end else begin
                     os_layer       = kc[7:0];
                     os_layer_armed = 1'b1;
                     r.layer_on     = 1'b1;
                     r.layer_index  = os_layer;
                  end
               end
            end
         end else begin
            if ((os_mods != 0 || os_layer_armed) && !os_locked && !pressed && kc != 0) begin
               cancel_one_shot(r);
            end
            if (pressed) begin
               last_os_key = '0;
               os_streak   = '0;
            end
            r.pass_through = 1'b1;
         end
      end
      r.mods_pending = os_mods;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         if (error_count < MAX_REPORTS) begin
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
         end
         error_count++;
      end
   endfunction

   // response side: stall pattern, long hold-off, result check, watchdog
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pass_through     = rsp_tdata[0];
         got.mod_press_mask   = rsp_tdata[8:1];
         got.mod_release_mask = rsp_tdata[16:9];
         got.layer_on         = rsp_tdata[17];
         got.layer_off        = rsp_tdata[18];
         got.layer_index      = rsp_tdata[26:19];
         got.mods_pending     = rsp_tdata[34:27];
         if (key_actions_q.size() == 0) begin
            if (error_count < MAX_REPORTS) $display("response transfer with none expected");
            error_count++;
         end else begin
            want = key_actions_q.pop_front();
            check_field("pass_through", 32'(want.pass_through), 32'(got.pass_through));
            check_field("mod_press_mask", 32'(want.mod_press_mask),
                        32'(got.mod_press_mask));
            check_field("mod_release_mask", 32'(want.mod_release_mask),
                        32'(got.mod_release_mask));
            check_field("layer_on", 32'(want.layer_on), 32'(got.layer_on));
            check_field("layer_off", 32'(want.layer_off), 32'(got.layer_off));
            check_field("layer_index", 32'(want.layer_index), 32'(got.layer_index));
            check_field("mods_pending", 32'(want.mods_pending), 32'(got.mods_pending));
         end
      end

      if (hold_requests != hold_served) begin
         hold_served   = hold_requests;
         rsp_hold_left = HOLD_CYCLES;
      end

      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 2);
            rsp_mode_left = $urandom_range(10, 80);
         end
         rsp_mode_left--;
         case (rsp_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end

      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_event(input logic cmd, input logic [15:0] kc, input logic pressed,
                             input logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(20, 100);
         end else begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(ReqDataW - 49){1'b0}}, stamp, pressed, kc};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      key_actions_q.push_back(predict_key_actions(cmd, kc, pressed, stamp));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (key_actions_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MOD_PREFIX:   cfg.mod_prefix   = value[7:0];
         CSR_LAYER_PREFIX: cfg.layer_prefix = value[7:0];
         CSR_TAP_TOGGLE:   cfg.tap_toggle   = value[7:0];
         default:          cfg.timeout_ms   = value;
      endcase
   endtask

   task automatic configure(input logic [7:0] mod_p, input logic [7:0] layer_p,
                            input logic [7:0] toggle, input logic [31:0] expiry);
      drain();
      write_reg(CSR_MOD_PREFIX, {24'b0, mod_p});
      write_reg(CSR_LAYER_PREFIX, {24'b0, layer_p});
      write_reg(CSR_TAP_TOGGLE, {24'b0, toggle});
      write_reg(CSR_TIMEOUT, expiry);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_event();
      int          kind;
      int          taps;
      logic [7:0]  lo;
      logic [15:0] kc;
      logic [31:0] delta;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
         0: lo = 8'h01;
         1: lo = 8'h80;
         2: lo = 8'h00;
         3: lo = 8'h12;
         default: lo = 8'($urandom);
      endcase
      if (kind < 30) begin
         kc   = {($urandom_range(0, 1) != 0) ? cfg.mod_prefix : cfg.layer_prefix, lo};
         taps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 8) : 1;
         repeat (taps) begin
            cur_time = cur_time + $urandom_range(0, 300);
            send_event(CMD_KEY, kc, 1'b1, cur_time);
            if ($urandom_range(0, 1) != 0) send_event(CMD_KEY, kc, 1'b0, cur_time + 10);
         end
      end else if (kind < 40) begin
         kc = {($urandom_range(0, 1) != 0) ? cfg.mod_prefix : cfg.layer_prefix, lo};
         send_event(CMD_KEY, kc, 1'b0, cur_time);
      end else if (kind < 60) begin
         kc = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
         cur_time = cur_time + $urandom_range(0, 200);
         if ($urandom_range(0, 3) != 0) send_event(CMD_KEY, kc, 1'b1, cur_time);
         if ($urandom_range(0, 3) != 0) send_event(CMD_KEY, kc, 1'b0, cur_time + 5);
      end else if (kind < 85) begin
         case ($urandom_range(0, 3))
            0: delta = $urandom_range(0, 200);
            1: delta = cfg.timeout_ms - 32'd2 + $urandom_range(0, 4);
            2: delta = $urandom_range(0, 4000);
            default: delta = $urandom;
         endcase
         cur_time = cur_time + delta;
         send_event(CMD_TICK, 16'($urandom), 1'($urandom), cur_time);
      end else begin
         send_event(1'($urandom), 16'($urandom), 1'($urandom), $urandom);
      end
   endtask

   task automatic test_one_shot_basics();
      send_event(CMD_KEY, 16'h5501, 1'b1, 32'd100);
      send_event(CMD_KEY, 16'h5501, 1'b0, 32'd110);
      send_event(CMD_KEY, 16'h0004, 1'b1, 32'd120);
      send_event(CMD_KEY, 16'h0004, 1'b0, 32'd130);
      send_event(CMD_KEY, 16'h5403, 1'b1, 32'd200);
      send_event(CMD_KEY, 16'h54FF, 1'b1, 32'd210);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'd3210);
      send_event(CMD_TICK, 16'hFFFF, 1'b1, 32'd3211);
   endtask

   task automatic test_tap_lock();
      repeat (5) send_event(CMD_KEY, 16'h5580, 1'b1, 32'd4000);
      send_event(CMD_KEY, 16'h0029, 1'b0, 32'd4010);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'd100000);
      send_event(CMD_KEY, 16'h5580, 1'b1, 32'd100010);
   endtask

   task automatic test_timeout_wrap();
      send_event(CMD_KEY, 16'h5540, 1'b1, 32'hFFFF_FF00);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'h0000_0100);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'h0000_0C00);
   endtask

   task automatic test_special_keys();
      // equal prefixes, keycode zero as one-shot key, expiry off
      configure(8'h00, 8'h00, 8'd5, 32'd0);
      send_event(CMD_KEY, 16'h0000, 1'b1, 32'd10);
      send_event(CMD_KEY, 16'h0000, 1'b1, 32'd20);
      send_event(CMD_KEY, 16'h0042, 1'b1, 32'd30);
      send_event(CMD_KEY, 16'h0000, 1'b0, 32'd40);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'hFFFF_FFFF);
      // rearm over a pending mask, lock on first tap, cancel on the next
      configure(8'hFF, 8'hFF, 8'd1, 32'd1);
      send_event(CMD_KEY, 16'hFFFF, 1'b1, 32'd5);
      send_event(CMD_TICK, 16'h0000, 1'b0, 32'h8000_0000);
      send_event(CMD_KEY, 16'hFFFF, 1'b1, 32'd6);
   endtask

   task automatic test_streak_saturation();
      configure(8'd85, 8'd84, 8'd0, 32'd0);
      repeat (260) send_event(CMD_KEY, 16'h5511, 1'b1, 32'd50);
      configure(8'd85, 8'd84, 8'd255, 32'd0);
      send_event(CMD_KEY, 16'h5511, 1'b1, 32'd60);
      send_event(CMD_KEY, 16'h5511, 1'b1, 32'd70);
   endtask

   task automatic test_output_backpressure();
      configure(8'd85, 8'd84, 8'd5, 32'd3000);
      hold_requests++;
      repeat (40) send_random_event();
   endtask

   task automatic test_random_traffic();
      int pass_idx;
      int start_count;
      for (pass_idx = 0; pass_idx < 6; pass_idx++) begin
         case (pass_idx)
            0: configure(8'd85, 8'd84, 8'd5, 32'd3000);
            1: configure(8'h00, 8'hFF, 8'd1, 32'd1);
            2: configure(8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF);
            3: configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)),
                         $urandom_range(0, 5000));
            4: configure(8'd85, 8'd84, 8'd2, 32'd50);
            default: configure(8'd85, 8'd84, 8'd0, 32'd0);
         endcase
         start_count = sent_count;
         while (sent_count - start_count < ITEMS_PER_PASS) begin
            send_random_event();
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tuser      = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_MOD_PREFIX;
      csr_wdata      = '0;
      cfg            = '{mod_prefix: 8'd85, layer_prefix: 8'd84, tap_toggle: 8'd5,
                         timeout_ms: 32'd3000};
      os_mods        = '0;
      os_layer_armed = 1'b0;
      os_layer       = '0;
      os_locked      = 1'b0;
      os_armed_at    = '0;
      os_streak      = '0;
      last_os_key    = '0;
      error_count    = 0;
      sent_count     = 0;
      burst_left     = 0;
      hold_requests  = 0;
      cur_time       = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_one_shot_basics();
      test_tap_lock();
      test_timeout_wrap();
      test_special_keys();
      test_streak_saturation();
      test_output_backpressure();
      test_random_traffic();

      drain();
      repeat (8) @(posedge clock);
      if (key_actions_q.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/osml_pkg.sv
design/osml_front.sv
design/osml_queue.sv
design/osml_back.sv
design/one_shot_modifier_layer.sv
tb/tb_one_shot_modifier_layer.sv
